FILE: hw/rtl/bbrt_pkg.sv
`timescale 1ns / 1ps

package bbrt_pkg;

	// table geometry
	localparam int TABLE_ENTRIES = 32;
	localparam int PAGE_BITS     = 5;
	localparam int BLOCK_BITS    = 16;
	localparam int SECTOR_BITS   = BLOCK_BITS + PAGE_BITS;
	localparam int SLOT_BITS     = 5;
	localparam int CELL_IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	// tag value of a slot that holds no bad block
	localparam logic [BLOCK_BITS-1:0] TAG_UNUSED = '1;

	// stream widths
	localparam int IN_DATA_BITS  = 64;
	localparam int IN_USER_BITS  = 2;
	localparam int OUT_DATA_BITS = 32;
	localparam int OUT_USER_BITS = 2;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_MAP  = 2'd1,
		CMD_MARK = 2'd2
	} cmd_t;

	// request and partial answer as it walks down the row of cells
	typedef struct packed {
		logic                   valid;
		logic [1:0]             cmd;
		logic [SECTOR_BITS-1:0] sector;
		logic [SLOT_BITS-1:0]   load_slot;
		logic [BLOCK_BITS-1:0]  load_bad;
		logic [BLOCK_BITS-1:0]  load_spare;
		logic                   match_found;
		logic [BLOCK_BITS-1:0]  match_spare;
		logic [SLOT_BITS-1:0]   match_slot;
		logic                   free_found;
		logic [SLOT_BITS-1:0]   free_slot;
	} token_t;

endpackage

FILE: hw/rtl/bad_block_remap_table.sv
`timescale 1ns / 1ps

// channel  dir  tdata (low bit first)                              tuser
// s_*      in   sector_address, load_slot, load_bad_block,         command
//               load_spare_block, zero fill to 64
// m_*      out  mapped_sector, slot_used, zero fill to 32           remapped, status
//
// each of the TABLE_ENTRIES cells holds one entry; a request steps one cell per cycle while
// the output is not stalled, and passes through every cell and then the output register.
// requests follow each other in successive cycles: one transfer per cycle sustained unless the output stalls.
// a stall on the output freezes the whole row of cells and holds s_tready low.
// reset leaves every slot unused and the row empty.

module bad_block_remap_table (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// sector_address, load_slot, load_bad_block, load_spare_block
	input  logic [bbrt_pkg::IN_DATA_BITS-1:0]   s_tdata,
	// command
	input  logic [bbrt_pkg::IN_USER_BITS-1:0]   s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// mapped_sector, slot_used
	output logic [bbrt_pkg::OUT_DATA_BITS-1:0]  m_tdata,
	// remapped, status
	output logic [bbrt_pkg::OUT_USER_BITS-1:0]  m_tuser
);
	import bbrt_pkg::*;

	token_t                 chain [0:TABLE_ENTRIES];
	token_t                 last;
	logic                   advance;
	logic                   out_valid_q;
	logic [SECTOR_BITS-1:0] mapped_q;
	logic [SLOT_BITS-1:0]   slot_q;
	logic                   remapped_q;
	logic                   status_q;
	logic [SECTOR_BITS-1:0] mapped_d;
	logic [SLOT_BITS-1:0]   slot_d;
	logic                   remapped_d;
	logic                   status_d;

	// the row moves whenever the output register can take what falls out
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = advance;

	// request entering the first cell
	always_comb begin
		chain[0]             = '0;
		chain[0].valid       = s_tvalid;
		chain[0].cmd         = s_tuser;
		chain[0].sector      = s_tdata[0 +: SECTOR_BITS];
		chain[0].load_slot   = s_tdata[SECTOR_BITS +: SLOT_BITS];
		chain[0].load_bad    = s_tdata[SECTOR_BITS + SLOT_BITS +: BLOCK_BITS];
		chain[0].load_spare  = s_tdata[SECTOR_BITS + SLOT_BITS + BLOCK_BITS +: BLOCK_BITS];
	end

	// row of table cells
	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		bbrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.cell_idx (CELL_IDX_BITS'(i)),
			.tok_in   (chain[i]),
			.tok_out  (chain[i+1])
		);
	end

	assign last = chain[TABLE_ENTRIES];

	// result fields from the finished request
	always_comb begin
		remapped_d = 1'b0;
		status_d   = 1'b0;
		slot_d     = '0;
		case (last.cmd)
			CMD_LOAD: begin
				slot_d = last.load_slot;
			end
			CMD_MAP: begin
				remapped_d = last.match_found;
				if (last.match_found) begin
					slot_d = last.match_slot;
				end
			end
			CMD_MARK: begin
				status_d   = !last.free_found;
				remapped_d = last.free_found && last.match_found;
				if (last.free_found) begin
					slot_d = last.free_slot;
				end
			end
			default: begin
			end
		endcase
		mapped_d = remapped_d ? {last.match_spare, last.sector[PAGE_BITS-1:0]} : last.sector;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= last.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last.valid) begin
			mapped_q   <= mapped_d;
			slot_q     <= slot_d;
			remapped_q <= remapped_d;
			status_q   <= status_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {(OUT_DATA_BITS - SECTOR_BITS - SLOT_BITS)'(0), slot_q, mapped_q};
	assign m_tuser  = {status_q, remapped_q};

endmodule

FILE: hw/rtl/bbrt_cell.sv
`timescale 1ns / 1ps

module bbrt_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  logic [bbrt_pkg::CELL_IDX_BITS-1:0] cell_idx,
	input  bbrt_pkg::token_t               tok_in,
	output bbrt_pkg::token_t               tok_out
);
	import bbrt_pkg::*;

	logic [BLOCK_BITS-1:0] tag_q;
	logic [BLOCK_BITS-1:0] spare_q;
	token_t                tok_q;
	token_t                tok_nxt;
	logic [BLOCK_BITS-1:0] blk;
	logic                  blk_used;
	logic                  hit;
	logic                  is_free;
	logic                  slot_sel;
	logic                  wr_load;
	logic                  wr_mark;
	logic [SLOT_BITS-1:0]  my_slot;

	assign blk      = tok_in.sector[PAGE_BITS +: BLOCK_BITS];
	assign blk_used = (blk != TAG_UNUSED);
	assign hit      = blk_used && (tag_q == blk);
	assign is_free  = (tag_q == TAG_UNUSED);
	assign slot_sel = (32'(tok_in.load_slot) == 32'(cell_idx));
	assign my_slot  = SLOT_BITS'(cell_idx);

	// per-cell step: load the selected slot, compare, claim a free slot, pick up the spare
	always_comb begin
		tok_nxt = tok_in;
		wr_load = 1'b0;
		wr_mark = 1'b0;
		case (tok_in.cmd)
			CMD_LOAD: begin
				wr_load = slot_sel;
			end
			CMD_MAP: begin
				if (hit && !tok_in.match_found) begin
					tok_nxt.match_found = 1'b1;
					tok_nxt.match_spare = spare_q;
					tok_nxt.match_slot  = my_slot;
				end
			end
			CMD_MARK: begin
				if (is_free && !tok_in.free_found) begin
					wr_mark            = 1'b1;
					tok_nxt.free_found = 1'b1;
					tok_nxt.free_slot  = my_slot;
					// the newly written tag matches unless it is the unused tag or an earlier slot already did
					if (blk_used && !tok_in.match_found) begin
						tok_nxt.match_found = 1'b1;
						tok_nxt.match_spare = spare_q;
						tok_nxt.match_slot  = my_slot;
					end
				end else if (hit && !tok_in.match_found) begin
					tok_nxt.match_found = 1'b1;
					tok_nxt.match_spare = spare_q;
					tok_nxt.match_slot  = my_slot;
				end
			end
			default: begin
			end
		endcase
	end

	// entry storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q   <= '1;
			spare_q <= '1;
		end else if (advance && tok_in.valid) begin
			if (wr_load) begin
				tag_q   <= tok_in.load_bad;
				spare_q <= tok_in.load_spare;
			end else if (wr_mark) begin
				tag_q <= blk;
			end
		end
	end

	// hand the request to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (advance) begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: tb/sv/tb_bad_block_remap_table.sv
`timescale 1ns / 1ps

module tb_bad_block_remap_table;

	import bbrt_pkg::*;

	// command code with no operation behind it
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	// bit offsets inside the input tdata
	localparam int SLOT_LSB  = SECTOR_BITS;
	localparam int BAD_LSB   = SLOT_LSB + SLOT_BITS;
	localparam int SPARE_LSB = BAD_LSB + BLOCK_BITS;

	localparam int ITEMS_PER_PHASE  = 500;
	localparam int LONG_HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES    = TABLE_ENTRIES + 8;
	localparam int MAX_REPORTS      = 10;

	typedef struct packed {
		logic [SECTOR_BITS-1:0] sector;
		logic [SLOT_BITS-1:0]   slot;
		logic                   remapped;
		logic                   status;
	} remap_result_t;

	// shadow of the remap table plus the results still owed by the block
	class remap_table_checker;
		logic [BLOCK_BITS-1:0] tag [TABLE_ENTRIES];
		logic [BLOCK_BITS-1:0] spare [TABLE_ENTRIES];
		remap_result_t pending_remaps [$];
		int mismatches;

		function new();
			for (int i = 0; i < TABLE_ENTRIES; i++) begin
				tag[i]   = TAG_UNUSED;
				spare[i] = '1;
			end
			mismatches = 0;
		endfunction

		// first used slot holding this block, -1 if none
		function int find_tag(logic [BLOCK_BITS-1:0] blk);
			if (blk == TAG_UNUSED)
				return -1;
			for (int i = 0; i < TABLE_ENTRIES; i++)
				if (tag[i] == blk)
					return i;
			return -1;
		endfunction

		// update the shadow table and queue the answer for one request
		function void note_request(logic [1:0] cmd, logic [SECTOR_BITS-1:0] sector,
				logic [SLOT_BITS-1:0] lslot, logic [BLOCK_BITS-1:0] lbad,
				logic [BLOCK_BITS-1:0] lspare);
			logic [BLOCK_BITS-1:0] blk;
			int hit;
			int free_slot;
			remap_result_t res;
			blk = sector[PAGE_BITS +: BLOCK_BITS];
			res = '{sector: sector, slot: '0, remapped: 1'b0, status: 1'b0};
			case (cmd)
				CMD_LOAD: begin
					if (int'(lslot) < TABLE_ENTRIES) begin
						tag[lslot]   = lbad;
						spare[lslot] = lspare;
					end
					res.slot = lslot;
				end
				CMD_MAP: begin
					hit = find_tag(blk);
					if (hit >= 0) begin
						res.sector   = {spare[CELL_IDX_BITS'(hit)], sector[PAGE_BITS-1:0]};
						res.remapped = 1'b1;
						res.slot     = SLOT_BITS'(hit);
					end
				end
				CMD_MARK: begin
					free_slot = -1;
					for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
						if (tag[i] == TAG_UNUSED)
							free_slot = i;
					if (free_slot < 0) begin
						res.status = 1'b1;
					end else begin
						// the spare already in the slot is kept
						tag[CELL_IDX_BITS'(free_slot)] = blk;
						res.slot = SLOT_BITS'(free_slot);
						hit = find_tag(blk);
						if (hit >= 0) begin
							res.sector   = {spare[CELL_IDX_BITS'(hit)], sector[PAGE_BITS-1:0]};
							res.remapped = 1'b1;
						end
					end
				end
				default: ;
			endcase
			pending_remaps.push_back(res);
		endfunction

		// compare one result transfer with the oldest owed answer
		function void check_result(remap_result_t got);
			remap_result_t want;
			if (pending_remaps.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result sector=%h slot=%0d remapped=%b status=%b",
						$time, got.sector, got.slot, got.remapped, got.status);
				return;
			end
			want = pending_remaps.pop_front();
			if (got.sector != want.sector || got.slot != want.slot ||
					got.remapped != want.remapped || got.status != want.status) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: result differs", $time);
					$display("  sector   exp %h got %h", want.sector, got.sector);
					$display("  slot     exp %0d got %0d", want.slot, got.slot);
					$display("  remapped exp %b got %b", want.remapped, got.remapped);
					$display("  status   exp %b got %b", want.status, got.status);
				end
			end
		endfunction
	endclass

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [IN_DATA_BITS-1:0]    s_tdata;
	logic [IN_USER_BITS-1:0]    s_tuser;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [OUT_DATA_BITS-1:0]   m_tdata;
	logic [OUT_USER_BITS-1:0]   m_tuser;

	remap_table_checker table_chk;
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_requests;
	int items_sent;
	logic [BLOCK_BITS-1:0] block_pool [TABLE_ENTRIES];

	bad_block_remap_table u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// 2 ns clock
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watch both channels and feed the checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				table_chk.note_request(s_tuser, s_tdata[SECTOR_BITS-1:0],
					s_tdata[SLOT_LSB +: SLOT_BITS], s_tdata[BAD_LSB +: BLOCK_BITS],
					s_tdata[SPARE_LSB +: BLOCK_BITS]);
			if (m_tvalid && m_tready)
				table_chk.check_result('{sector: m_tdata[SECTOR_BITS-1:0],
					slot: m_tdata[SECTOR_BITS +: SLOT_BITS],
					remapped: m_tuser[0], status: m_tuser[1]});
		end
	end

	// result side: random stalls, plus a long hold-off on request
	initial begin : result_sink
		int holds_served;
		int hold_left;
		holds_served = 0;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				hold_left = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// offer one request and wait for its transfer
	task automatic send_request(input logic [1:0] cmd, input logic [SECTOR_BITS-1:0] sector,
			input logic [SLOT_BITS-1:0] lslot, input logic [BLOCK_BITS-1:0] lbad,
			input logic [BLOCK_BITS-1:0] lspare);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {{(IN_DATA_BITS - SPARE_LSB - BLOCK_BITS){1'b0}}, lspare, lbad, lslot, sector};
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
	endtask

	// stop offering and let every owed result come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		// let the checker see the transfer of the last edge first
		@(posedge clk);
		while (table_chk.pending_remaps.size() != 0)
			@(posedge clk);
	endtask

	// free every slot in order
	task automatic clear_table();
		for (int i = 0; i < TABLE_ENTRIES; i++)
			send_request(CMD_LOAD, SECTOR_BITS'($urandom), SLOT_BITS'(i), TAG_UNUSED,
				BLOCK_BITS'($urandom));
	endtask

	// one random request, mostly on blocks from the block pool
	task automatic random_request();
		int pick;
		logic [BLOCK_BITS-1:0] blk;
		logic [SECTOR_BITS-1:0] sector;
		logic [SLOT_BITS-1:0] lslot;
		logic [BLOCK_BITS-1:0] lbad;
		logic [BLOCK_BITS-1:0] lspare;
		pick = $urandom_range(99);
		if ($urandom_range(3) != 0) begin
			blk = block_pool[CELL_IDX_BITS'($urandom_range(TABLE_ENTRIES - 1))];
		end else begin
			blk = BLOCK_BITS'($urandom);
			block_pool[CELL_IDX_BITS'($urandom_range(TABLE_ENTRIES - 1))] = blk;
		end
		sector = {blk, PAGE_BITS'($urandom)};
		lslot  = SLOT_BITS'($urandom);
		lbad   = BLOCK_BITS'($urandom);
		lspare = BLOCK_BITS'($urandom);
		if ($urandom_range(119) == 0)
			clear_table();
		else if (pick < 6)
			send_request(CMD_UNKNOWN, SECTOR_BITS'($urandom), lslot, lbad, lspare);
		else if (pick < 32)
			send_request(CMD_LOAD, SECTOR_BITS'($urandom), lslot,
				($urandom_range(1) == 0) ? TAG_UNUSED : blk, lspare);
		else if (pick < 68)
			send_request(CMD_MAP, sector, lslot, lbad, lspare);
		else
			send_request(CMD_MARK, sector, lslot, lbad, lspare);
	endtask

	// hard stop
	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	// main sequence
	initial begin
		bit hold_done;
		bit pause_done;
		hold_done  = 1'b0;
		pause_done = 1'b0;
		table_chk = new();
		for (int i = 0; i < TABLE_ENTRIES; i++)
			block_pool[i] = BLOCK_BITS'($urandom);
		items_sent    = 0;
		hold_requests = 0;
		tx_idle_pct   = 7;
		rx_idle_pct   = 60;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// misses on an empty table, block zero and the unused tag
		send_request(CMD_MAP, '0, '0, '0, '0);
		send_request(CMD_MAP, '1, '1, '1, '1);
		// loads at both ends of the slot range, one leaving its slot unused
		send_request(CMD_LOAD, '1, 5'd0, 16'h0000, 16'hFFFF);
		send_request(CMD_LOAD, '0, 5'd31, TAG_UNUSED, 16'h0000);
		send_request(CMD_LOAD, 21'h15555, 5'h15, 16'hAAAA, 16'h5555);
		send_request(CMD_LOAD, 21'h0AAAA, 5'h0A, 16'h5555, 16'hAAAA);
		// hits with extreme pages and spares
		send_request(CMD_MAP, {16'h0000, 5'h1F}, '0, '0, '0);
		send_request(CMD_MAP, {16'hAAAA, 5'h00}, '1, '1, '1);
		send_request(CMD_MAP, {16'h5555, 5'h0A}, '0, '0, '0);
		// mark a new block, an already listed one, and the unused tag
		send_request(CMD_MARK, {16'h1234, 5'h07}, '0, '0, '0);
		send_request(CMD_MARK, {16'hAAAA, 5'h1F}, '1, '1, '1);
		send_request(CMD_MARK, {16'hFFFF, 5'h11}, '0, '0, '0);
		send_request(CMD_MAP, {16'hFFFF, 5'h11}, '0, '0, '0);
		// free the later entry of a duplicated block, the earlier one still answers
		send_request(CMD_LOAD, '0, 5'h15, TAG_UNUSED, 16'h0F0F);
		send_request(CMD_MAP, {16'hAAAA, 5'h03}, '0, '0, '0);
		send_request(CMD_MAP, {16'h1234, 5'h1E}, '0, '0, '0);
		send_request(CMD_UNKNOWN, '1, '1, '1, '1);
		send_request(CMD_UNKNOWN, '0, '0, '0, '0);
		wait_drained();

		// three random phases with different idle patterns
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 7;
					rx_idle_pct = 60;
				end
				1: begin
					tx_idle_pct = 60;
					rx_idle_pct = 7;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n = n) begin
				if (phase == 0 && !hold_done && n >= ITEMS_PER_PHASE / 2) begin
					hold_done = 1'b1;
					hold_requests <= hold_requests + 1;
				end
				if (phase == 1 && !pause_done && n >= ITEMS_PER_PHASE / 2) begin
					pause_done = 1'b1;
					wait_drained();
				end
				items_sent = 0;
				random_request();
				n += items_sent;
			end
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (table_chk.mismatches == 0 && table_chk.pending_remaps.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
